### src/bpi_pkg.sv
// Shared types and constants for the bilinear pixel interpolator.
// Fixed field widths, configuration register codes and inter-stage structs.
// No dependencies.
package bpi_pkg;

  localparam int COL_W    = 8;
  localparam int ROW_W    = 8;
  localparam int PIX_IN_W = 16;
  localparam int COORD_W  = 16;
  localparam int OUT_W    = 24;
  localparam int REG_W    = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] IMAGE_SIZE_RESET = 9'd256;

  // Pipeline advance strobes, one per stage after the input register
  typedef struct packed {
    logic adv_b;
    logic adv_c;
    logic adv_d;
  } pipe_adv_t;

  // Corner bookkeeping: parity of x0/y0 picks the bank for each corner,
  // corner_ok bit order is q00, q10, q01, q11 from bit 0 upwards
  typedef struct packed {
    logic       x_odd;
    logic       y_odd;
    logic [3:0] corner_ok;
  } corner_info_t;

endpackage

### src/bpi_if.sv
// Valid/ready channel interfaces for sample items and result items.
// Depends on bpi_pkg for the field widths.
interface bpi_sample_if;
  import bpi_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [COL_W-1:0]    write_col;
  logic [ROW_W-1:0]    write_row;
  logic [PIX_IN_W-1:0] pixel_value;
  logic [COORD_W-1:0]  query_x;
  logic [COORD_W-1:0]  query_y;

  modport source (output valid, kind, write_col, write_row, pixel_value, query_x, query_y,
                  input ready);
  modport sink (input valid, kind, write_col, write_row, pixel_value, query_x, query_y,
                output ready);
endinterface

interface bpi_result_if;
  import bpi_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] interp_value;

  modport source (output valid, interp_value, input ready);
  modport sink (input valid, interp_value, output ready);
endinterface

### src/bpi_ram.sv
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module bpi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/bpi_corner_fetch.sv
// Address generation, four-bank pixel store and corner weights (stage A to B).
// Depends on bpi_pkg and bpi_ram.
module bpi_corner_fetch #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic                               clk,
  input  bpi_pkg::pipe_adv_t                 adv,
  input  logic                               a_valid,
  input  logic                               a_kind,
  input  logic [bpi_pkg::COL_W-1:0]          a_write_col,
  input  logic [bpi_pkg::ROW_W-1:0]          a_write_row,
  input  logic [bpi_pkg::PIX_IN_W-1:0]       a_pixel_value,
  input  logic [bpi_pkg::COORD_W-1:0]        a_query_x,
  input  logic [bpi_pkg::COORD_W-1:0]        a_query_y,
  input  logic [$clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1)-1:0] width_eff,
  input  logic [$clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1)-1:0] height_eff,
  output logic [PIXEL_BITS-1:0]              bank_q [4],
  output bpi_pkg::corner_info_t              info,
  output logic [2*FRAC_BITS:0]               weight [4]
);
  import bpi_pkg::*;

  localparam int DIM_W   = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int XW      = COORD_W + 1 - FRAC_BITS;
  localparam int IW      = XW > COL_W ? XW : COL_W;
  localparam int CMP_W   = (IW > DIM_W ? IW : DIM_W) + 1;
  localparam int HALF_W  = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H  = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int AW      = $clog2(BANK_DEPTH > 1 ? BANK_DEPTH : 2);
  localparam int WT_W    = 2 * FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE_FX = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // Bank-local address of a half-resolution row/column pair; out-of-store
  // positions map to zero since their data is discarded later
  function automatic logic [AW-1:0] bank_addr(input logic [IW-1:0] rh,
                                               input logic [IW-1:0] ch);
    logic          in_store;
    logic [AW-1:0] addr;
    in_store = (CMP_W'(rh) < CMP_W'(HALF_H)) && (CMP_W'(ch) < CMP_W'(HALF_W));
    addr = AW'(rh) * AW'(HALF_W) + AW'(ch);
    return in_store ? addr : '0;
  endfunction

  logic [IW-1:0] x0, x1, y0, y1;
  logic [IW-1:0] x_even_h, x_odd_h, y_even_h, y_odd_h;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [FRAC_BITS:0]   gx, gy;
  logic [AW-1:0]  rd_addr [4];
  logic [AW-1:0]  wr_addr;
  logic [1:0]     wr_bank;
  logic           wr_fire;
  logic           x0_ok, x1_ok, y0_ok, y1_ok;
  corner_info_t   info_next;
  logic [WT_W-1:0] weight_next [4];

  always_comb begin
    x0 = IW'(a_query_x >> FRAC_BITS);
    y0 = IW'(a_query_y >> FRAC_BITS);
    x1 = x0 + IW'(1);
    y1 = y0 + IW'(1);
    // even neighbour sits in bank column 0, odd one in bank column 1
    x_even_h = (x0[0] ? x1 : x0) >> 1;
    x_odd_h  = (x0[0] ? x0 : x1) >> 1;
    y_even_h = (y0[0] ? y1 : y0) >> 1;
    y_odd_h  = (y0[0] ? y0 : y1) >> 1;

    rd_addr[0] = bank_addr(y_even_h, x_even_h);
    rd_addr[1] = bank_addr(y_even_h, x_odd_h);
    rd_addr[2] = bank_addr(y_odd_h,  x_even_h);
    rd_addr[3] = bank_addr(y_odd_h,  x_odd_h);

    x0_ok = CMP_W'(x0) < CMP_W'(width_eff);
    x1_ok = CMP_W'(x1) < CMP_W'(width_eff);
    y0_ok = CMP_W'(y0) < CMP_W'(height_eff);
    y1_ok = CMP_W'(y1) < CMP_W'(height_eff);

    info_next.x_odd     = x0[0];
    info_next.y_odd     = y0[0];
    info_next.corner_ok = {x1_ok & y1_ok, x0_ok & y1_ok, x1_ok & y0_ok, x0_ok & y0_ok};

    fx = a_query_x[FRAC_BITS-1:0];
    fy = a_query_y[FRAC_BITS-1:0];
    gx = ONE_FX - {1'b0, fx};
    gy = ONE_FX - {1'b0, fy};
    weight_next[0] = WT_W'(gx) * WT_W'(gy);
    weight_next[1] = WT_W'(fx) * WT_W'(gy);
    weight_next[2] = WT_W'(gx) * WT_W'(fy);
    weight_next[3] = WT_W'(fx) * WT_W'(fy);

    // drop stores that fall outside the physical array
    wr_fire = a_valid && (a_kind == KIND_WRITE) && adv.adv_b
              && (CMP_W'(a_write_col) < CMP_W'(MAX_WIDTH))
              && (CMP_W'(a_write_row) < CMP_W'(MAX_HEIGHT));
    wr_bank = {a_write_row[0], a_write_col[0]};
    wr_addr = bank_addr(IW'(a_write_row >> 1), IW'(a_write_col >> 1));
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bpi_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr_fire && (wr_bank == 2'(b))),
      .waddr (wr_addr),
      .wdata (PIXEL_BITS'(a_pixel_value)),
      .re    (adv.adv_b),
      .raddr (rd_addr[b]),
      .rdata (bank_q[b])
    );
  end

  always_ff @(posedge clk) begin
    if (adv.adv_b) begin
      info   <= info_next;
      weight <= weight_next;
    end
  end

endmodule

### src/bpi_blend.sv
// Corner selection, weighting and summation (stages C and D).
// Depends on bpi_pkg.
module bpi_blend #(
  parameter int FRAC_BITS  = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic                          clk,
  input  bpi_pkg::pipe_adv_t            adv,
  input  logic [PIXEL_BITS-1:0]         bank_q [4],
  input  bpi_pkg::corner_info_t         info,
  input  logic [2*FRAC_BITS:0]          weight [4],
  output logic [bpi_pkg::OUT_W-1:0]     interp_value
);
  import bpi_pkg::*;

  localparam int WT_W = 2 * FRAC_BITS + 1;
  localparam int PW   = PIXEL_BITS + WT_W;
  localparam int SW   = PW + 2;

  logic [PW-1:0] prod_next [4];
  logic [PW-1:0] prod [4];
  logic [SW-1:0] sum;

  // map each logical corner onto its bank, zero it when outside the image
  always_comb begin
    logic [1:0]            kk;
    logic [1:0]            bank;
    logic [PIXEL_BITS-1:0] q;
    for (int k = 0; k < 4; k++) begin
      kk   = 2'(k);
      bank = {info.y_odd ^ kk[1], info.x_odd ^ kk[0]};
      q    = info.corner_ok[k] ? bank_q[bank] : '0;
      prod_next[k] = PW'(q) * PW'(weight[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.adv_c) begin
      prod <= prod_next;
    end
  end

  always_comb begin
    sum = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + SW'(prod[3]);
  end

  always_ff @(posedge clk) begin
    if (adv.adv_d) begin
      interp_value <= OUT_W'(sum >> FRAC_BITS);
    end
  end

endmodule

### src/bilinear_pixel_interpolator.sv
// Top level of the bilinear pixel interpolator: handshake, configuration, pipeline control.
// Depends on bpi_pkg, bpi_if, bpi_corner_fetch and bpi_blend.
//
//   channel     | dir | handshake     | payload
//   ------------+-----+---------------+------------------------------------------------
//   sample_in   | in  | valid/ready   | kind, write_col, write_row, pixel_value,
//               |     |               | query_x, query_y
//   interp_out  | out | valid/ready   | interp_value
//   cfg_*       | in  | cfg_we strobe | cfg_index, cfg_data (image_width, image_height)
//
// One transaction accepted per cycle while no back-pressure reaches the input. A query
// result passes through the input register, the registered read of the four-bank store,
// the product register and the output register before it is presented. Write transactions
// retire as they leave the input register.
// Reset (synchronous) clears the valid bits and sets both image dimensions to 256;
// the pixel store is left untouched and is undefined until written.
// A stalled output holds its result; back-pressure moves up the valid chain,
// so empty stages keep filling while the output waits.
module bilinear_pixel_interpolator #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bpi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpi_pkg::REG_W-1:0]       cfg_data,
  bpi_sample_if.sink                      sample_in,
  bpi_result_if.source                    interp_out
);
  import bpi_pkg::*;

  localparam int DIM_W = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int EXT_W = (DIM_W > REG_W ? DIM_W : REG_W) + 1;

  // Configuration registers
  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;
  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;

  // Stage valid bits
  logic a_valid, b_valid, c_valid, d_valid;
  pipe_adv_t adv;
  logic adv_a;

  // Input register payload
  logic                a_kind;
  logic [COL_W-1:0]    a_write_col;
  logic [ROW_W-1:0]    a_write_row;
  logic [PIX_IN_W-1:0] a_pixel_value;
  logic [COORD_W-1:0]  a_query_x;
  logic [COORD_W-1:0]  a_query_y;

  logic [PIXEL_BITS-1:0] bank_q [4];
  corner_info_t          info;
  logic [2*FRAC_BITS:0]  weight [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_SIZE_RESET;
      image_height <= IMAGE_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the dimensions to the physical store size
  always_comb begin
    width_eff  = (EXT_W'(image_width) > EXT_W'(MAX_WIDTH)) ?
                 DIM_W'(MAX_WIDTH) : DIM_W'(image_width);
    height_eff = (EXT_W'(image_height) > EXT_W'(MAX_HEIGHT)) ?
                 DIM_W'(MAX_HEIGHT) : DIM_W'(image_height);
  end

  // Advance a stage when it is empty or the next stage advances too
  always_comb begin
    adv.adv_d = !d_valid || interp_out.ready;
    adv.adv_c = !c_valid || adv.adv_d;
    adv.adv_b = !b_valid || adv.adv_c;
    adv_a     = !a_valid || adv.adv_b;
  end

  assign sample_in.ready = adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid <= sample_in.valid;
      end
      // drop write transactions here: they finish at the store write
      if (adv.adv_b) begin
        b_valid <= a_valid && (a_kind == KIND_QUERY);
      end
      if (adv.adv_c) begin
        c_valid <= b_valid;
      end
      if (adv.adv_d) begin
        d_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_kind        <= sample_in.kind;
      a_write_col   <= sample_in.write_col;
      a_write_row   <= sample_in.write_row;
      a_pixel_value <= sample_in.pixel_value;
      a_query_x     <= sample_in.query_x;
      a_query_y     <= sample_in.query_y;
    end
  end

  bpi_corner_fetch #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_fetch (
    .clk           (clk),
    .adv           (adv),
    .a_valid       (a_valid),
    .a_kind        (a_kind),
    .a_write_col   (a_write_col),
    .a_write_row   (a_write_row),
    .a_pixel_value (a_pixel_value),
    .a_query_x     (a_query_x),
    .a_query_y     (a_query_y),
    .width_eff     (width_eff),
    .height_eff    (height_eff),
    .bank_q        (bank_q),
    .info          (info),
    .weight        (weight)
  );

  bpi_blend #(
    .FRAC_BITS  (FRAC_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_blend (
    .clk          (clk),
    .adv          (adv),
    .bank_q       (bank_q),
    .info         (info),
    .weight       (weight),
    .interp_value (interp_out.interp_value)
  );

  assign interp_out.valid = d_valid;

  // Back-pressure reaches the input only when every stage is occupied
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !sample_in.ready |-> (a_valid && b_valid && c_valid && d_valid))
    else $error("input stalled while a pipeline stage is empty");

  // A write transaction never enters the result path
  a_write_dropped: assert property (@(posedge clk) disable iff (rst)
    (a_valid && (a_kind == KIND_WRITE) && adv.adv_b) |=> !b_valid)
    else $error("write transaction leaked into the result path");

  // A result only appears behind an item in the product stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(d_valid) |-> $past(c_valid))
    else $error("result raised without a product stage item");

endmodule

### tb/bpi_interp_checker.sv
// Checker for the bilinear pixel interpolator: mirrors the pixel store and image size.
// Predicts each query result and checks the result channel in order.
// Depends on bpi_pkg and the channel interfaces in bpi_if.
module bpi_interp_checker #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpi_pkg::REG_W-1:0]     cfg_data,
  bpi_sample_if                         samples,
  bpi_result_if                         results,
  output int                            faults,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpi_pkg::*;

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

  logic [PIXEL_BITS-1:0] pixels [MAX_WIDTH*MAX_HEIGHT];
  logic [REG_W-1:0]      width_reg = IMAGE_SIZE_RESET;
  logic [REG_W-1:0]      height_reg = IMAGE_SIZE_RESET;
  logic [OUT_W-1:0]      awaited_values [$];

  // Corners outside the image in use read as zero
  function automatic logic [63:0] corner(int col, int row);
    int cols;
    int rows;
    cols = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    rows = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    if (col >= cols || row >= rows) return 64'd0;
    return 64'(pixels[row*MAX_WIDTH + col]);
  endfunction

  function automatic logic [OUT_W-1:0] blend(logic [COORD_W-1:0] qx, logic [COORD_W-1:0] qy);
    int          x0;
    int          y0;
    logic [63:0] fx;
    logic [63:0] fy;
    logic [63:0] gx;
    logic [63:0] gy;
    logic [63:0] acc;
    x0  = int'(qx >> FRAC_BITS);
    y0  = int'(qy >> FRAC_BITS);
    fx  = 64'(qx) & (ONE - 64'd1);
    fy  = 64'(qy) & (ONE - 64'd1);
    gx  = ONE - fx;
    gy  = ONE - fy;
    acc = corner(x0, y0) * (gx * gy) + corner(x0 + 1, y0) * (fx * gy)
        + corner(x0, y0 + 1) * (gx * fy) + corner(x0 + 1, y0 + 1) * (fx * fy);
    return OUT_W'(acc >> FRAC_BITS);
  endfunction

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst) begin
      width_reg  = IMAGE_SIZE_RESET;
      height_reg = IMAGE_SIZE_RESET;
      awaited_values.delete();
      faults     = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_IMAGE_HEIGHT) height_reg = cfg_data;
      end
      // retire results before taking new queries, so a query accepted on this
      // edge never matches a result leaving on the same edge
      if (results.valid && results.ready) begin
        if (awaited_values.size() == 0) begin
          if (faults < 10)
            $display("unexpected interp_value 0x%06h with no query pending",
                     results.interp_value);
          faults = faults + 1;
        end else begin
          want = awaited_values.pop_front();
          if (results.interp_value !== want) begin
            if (faults < 10)
              $display("interp_value expected 0x%06h, got 0x%06h", want,
                       results.interp_value);
            faults = faults + 1;
          end
        end
      end
      if (samples.valid && samples.ready) begin
        if (samples.kind == KIND_WRITE) begin
          if (int'(samples.write_col) < MAX_WIDTH && int'(samples.write_row) < MAX_HEIGHT)
            pixels[int'(samples.write_row)*MAX_WIDTH + int'(samples.write_col)] =
              PIXEL_BITS'(samples.pixel_value);
        end else begin
          awaited_values.push_back(blend(samples.query_x, samples.query_y));
        end
      end
    end
    pending = awaited_values.size();
  end

endmodule

### tb/bilinear_pixel_interpolator_test.sv
// Top of the bilinear pixel interpolator testbench: clock, reset, stimulus and verdict.
// Depends on bpi_pkg, bpi_if, the bilinear_pixel_interpolator block and bpi_interp_checker.
module bilinear_pixel_interpolator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bpi_pkg::*;

  localparam int MAX_W    = 256;
  localparam int MAX_H    = 256;
  localparam int FRAC     = 8;
  localparam int PIX_BITS = 16;

  // Four-stage pipeline; let it settle before touching the registers or ending
  localparam int LATENCY        = 4;
  localparam int SETTLE_CYCLES  = 2 * LATENCY;
  localparam int WATCHDOG_LIMIT = 2000;

  // Image sizes of the random phases: lower extremes, oversized values
  // (every register bit set) and a couple of small odd shapes
  localparam int NUM_SIZES = 5;
  localparam int SIZE_W [NUM_SIZES] = '{1, 511, 1, 5, 13};
  localparam int SIZE_H [NUM_SIZES] = '{1, 1, 511, 7, 9};

  // Idle modes run in this order inside every size phase
  localparam int NUM_MODES   = 4;
  localparam int GAP_PCT   [NUM_MODES] = '{0, 46, 0, 29};
  localparam int STALL_PCT [NUM_MODES] = '{0, 0, 46, 29};
  localparam int MODE_ITEMS  = 42;

  typedef struct packed {
    logic                kind;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [PIX_IN_W-1:0] value;
    logic [COORD_W-1:0]  qx;
    logic [COORD_W-1:0]  qy;
  } pixel_item_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  int                   faults;
  int                   pending;

  int gap_pct      = 0;
  int stall_pct    = 0;
  int cols_used    = MAX_W;
  int rows_used    = MAX_H;
  int last_col     = 0;
  int last_row     = 0;
  int quiet_cycles = 0;

  // Pixels handed to the block so far; queries must never touch an unwritten
  // pixel inside the image
  bit written [MAX_W*MAX_H];

  bpi_sample_if sample_ch();
  bpi_result_if result_ch();

  bilinear_pixel_interpolator #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .FRAC_BITS (FRAC),
    .PIXEL_BITS(PIX_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_in (sample_ch),
    .interp_out(result_ch)
  );

  bpi_interp_checker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .FRAC_BITS (FRAC),
    .PIXEL_BITS(PIX_BITS)
  ) i_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .samples  (sample_ch),
    .results  (result_ch),
    .faults   (faults),
    .pending  (pending)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: drop ready at random according to the current stall rate
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: end the run if no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item at a falling edge and hold it until it is accepted.
  // Random sender gaps are inserted before the item; returns at a falling edge.
  task automatic send(input pixel_item_t item);
    while ($urandom_range(99) < gap_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.kind        <= item.kind;
    sample_ch.write_col   <= item.col;
    sample_ch.write_row   <= item.row;
    sample_ch.pixel_value <= item.value;
    sample_ch.query_x     <= item.qx;
    sample_ch.query_y     <= item.qy;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write transaction; the query fields carry junk the block must ignore
  task automatic store_pixel(input int col, input int row, input logic [PIX_IN_W-1:0] value);
    pixel_item_t item;
    item.kind  = KIND_WRITE;
    item.col   = COL_W'(col);
    item.row   = ROW_W'(row);
    item.value = value;
    item.qx    = COORD_W'($urandom);
    item.qy    = COORD_W'($urandom);
    written[int'(item.row)*MAX_W + int'(item.col)] = 1'b1;
    last_col = int'(item.col);
    last_row = int'(item.row);
    send(item);
  endtask

  // Query transaction; the write fields carry junk the block must ignore
  task automatic ask(input logic [COORD_W-1:0] qx, input logic [COORD_W-1:0] qy);
    pixel_item_t item;
    item.kind  = KIND_QUERY;
    item.col   = COL_W'($urandom);
    item.row   = ROW_W'($urandom);
    item.value = PIX_IN_W'($urandom);
    item.qx    = qx;
    item.qy    = qy;
    send(item);
  endtask

  // Hold the sender until every result is back and the pipeline has emptied of
  // writes, then program both image size registers
  task automatic resize(input int w, input int h);
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= REG_W'(w);
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= REG_W'(h);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cols_used = (w > MAX_W) ? MAX_W : w;
    rows_used = (h > MAX_H) ? MAX_H : h;
  endtask

  function automatic logic [PIX_IN_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 20) return '1;
    return PIX_IN_W'($urandom);
  endfunction

  // Coordinate with 8 integer and 8 fraction bits: most often inside the image,
  // some next to the last written pixel (read-after-write), some on the image
  // edge and some anywhere in the full range
  function automatic logic [COORD_W-1:0] pick_coord(input int used, input int near);
    logic [7:0] whole;
    logic [7:0] frac;
    int         sel;
    sel = $urandom_range(99);
    if (sel < 40) whole = 8'($urandom_range(used - 1));
    else if (sel < 60) whole = 8'(near - int'($urandom_range(1)));
    else if (sel < 75) whole = 8'(used - int'($urandom_range(1)));
    else whole = 8'($urandom);
    sel = $urandom_range(99);
    if (sel < 10) frac = 8'h00;
    else if (sel < 20) frac = 8'hFF;
    else frac = 8'($urandom);
    return {whole, frac};
  endfunction

  // Write every pixel of the image in use that has not been written yet.
  // Pixels written earlier outside a smaller image are kept and not written again.
  task automatic fill_image();
    for (int r = 0; r < rows_used; r++) begin
      for (int c = 0; c < cols_used; c++) begin
        if (!written[r*MAX_W + c]) store_pixel(c, r, pick_value());
      end
    end
  endtask

  task automatic random_item();
    if ($urandom_range(99) < 30) begin
      if ($urandom_range(1) == 0)
        store_pixel($urandom_range(cols_used - 1), $urandom_range(rows_used - 1), pick_value());
      else
        store_pixel($urandom_range(MAX_W - 1), $urandom_range(MAX_H - 1), pick_value());
    end else begin
      ask(pick_coord(cols_used, last_col), pick_coord(rows_used, last_row));
    end
  endtask

  initial begin
    // initialise every input before the first edge
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = REG_IMAGE_WIDTH;
    cfg_data              = '0;
    sample_ch.valid       = 1'b0;
    sample_ch.kind        = KIND_WRITE;
    sample_ch.write_col   = '0;
    sample_ch.write_row   = '0;
    sample_ch.pixel_value = '0;
    sample_ch.query_x     = '0;
    sample_ch.query_y     = '0;
    result_ch.ready       = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset size of 256 x 256: corners around the origin
    // and the far corner, pixel extremes, queried straight after being written
    store_pixel(0, 0, 16'hFFFF);
    store_pixel(1, 0, 16'h0001);
    store_pixel(0, 1, 16'h8000);
    store_pixel(1, 1, 16'hFFFF);
    store_pixel(255, 255, 16'hFFFF);
    store_pixel(254, 255, 16'h1234);
    store_pixel(255, 254, 16'hABCD);
    store_pixel(254, 254, 16'h0000);
    ask(16'h0000, 16'h0000);   // whole pixel at full scale: largest result
    ask(16'h00FF, 16'h00FF);   // largest fractions
    ask(16'h0080, 16'h0080);
    ask(16'h0001, 16'h0000);
    ask(16'h0000, 16'h00FF);
    ask(16'hFEFF, 16'hFEFF);
    ask(16'hFFFF, 16'hFFFF);   // right and lower corners fall off the store
    ask(16'hFF80, 16'hFE40);

    // Zero width, then zero height: every query answers zero
    resize(0, 256);
    ask(16'h0080, 16'h0080);
    ask(16'hFEFF, 16'hFEFF);
    resize(256, 0);
    ask(16'h00FF, 16'h0001);
    ask(16'hFF80, 16'hFE40);

    // Random part: per image size, fill the image, then run each idle mode
    for (int s = 0; s < NUM_SIZES; s++) begin
      resize(SIZE_W[s], SIZE_H[s]);
      fill_image();
      for (int m = 0; m < NUM_MODES; m++) begin
        gap_pct   = GAP_PCT[m];
        stall_pct = STALL_PCT[m];
        repeat (MODE_ITEMS) random_item();
      end
    end

    // Drain: wait for every result, then let the pipeline run empty
    sample_ch.valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (faults == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
src/bpi_pkg.sv
src/bpi_if.sv
src/bpi_ram.sv
src/bpi_corner_fetch.sv
src/bpi_blend.sv
src/bilinear_pixel_interpolator.sv
tb/bpi_interp_checker.sv
tb/bilinear_pixel_interpolator_test.sv
